### rtl/bba_pkg.sv
// Shared types, constants and codes for the buddy block allocator.
package bba_pkg;

    localparam int MAX_BLOCKS = 1024;
    localparam int TOP_CLASS  = 10;
    localparam int IDX_W      = 10;
    localparam int LINK_W     = 11;
    localparam int CB_W       = 6;
    localparam int CLS_W      = 4;
    localparam int WANT_W     = 5;
    localparam int REQ_W      = 24;
    localparam int CFG_W      = 24;

    localparam logic [LINK_W-1:0] NO_LINK   = LINK_W'(MAX_BLOCKS);
    localparam logic [CB_W-1:0]   FREE_MARK = 6'h20;

    typedef enum logic [1:0] {
        OP_FORMAT = 2'd0,
        OP_ALLOC  = 2'd1,
        OP_FREE   = 2'd2,
        OP_NOP    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        RES_OK        = 2'd0,
        RES_TOO_LARGE = 2'd1,
        RES_NO_MEM    = 2'd2
    } res_t;

    typedef enum logic [1:0] {
        CFG_ATOM_LOG    = 2'd0,
        CFG_BLOCK_COUNT = 2'd1,
        CFG_MAX_REQUEST = 2'd2
    } cfg_idx_t;

    typedef enum logic [4:0] {
        ST_RST_CLEAR, ST_IDLE, ST_FMT_CLEAR, ST_FMT_CHK, ST_FMT_NEXT,
        ST_A_SIZE, ST_A_FIND, ST_W_INIT, ST_W_STEP, ST_D_RD, ST_D_WR,
        ST_SPLIT, ST_PUSH2, ST_A_FIN, ST_F_RD, ST_F_CHK, ST_F_MARK,
        ST_F_SET, ST_M_CHK, ST_M_CMP, ST_M_W1, ST_M_W2, ST_F_PUSH, ST_DONE
    } state_t;

    typedef enum logic [4:0] {
        CMD_NONE, CMD_START, CMD_CLEAR, CMD_FMT_CHK, CMD_FMT_NEXT,
        CMD_A_SIZE, CMD_A_FIND, CMD_W_INIT, CMD_W_STEP, CMD_D_RD, CMD_D_WR,
        CMD_SPLIT, CMD_PUSH2, CMD_A_FIN, CMD_F_RD, CMD_F_CHK, CMD_F_MARK,
        CMD_F_SET, CMD_M_CHK, CMD_M_W1, CMD_M_W2, CMD_F_PUSH, CMD_OUT
    } cmd_t;

    typedef struct packed {
        op_t  op;
        logic sweep_last;
        logic too_large;
        logic bin_found;
        logic walk_more;
        logic split_more;
        logic half_ok;
        logic fmt_fit;
        logic cls_zero;
        logic blk_out;
        logic f_reject;
        logic merge_go;
        logic bud_match;
    } dp_status_t;

endpackage

### rtl/bba_ctrl.sv
// Sequencer for format, allocate and free requests and result handshake.
module bba_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [1:0]          s_op,
    output logic                m_valid,
    input  logic                m_ready,
    output bba_pkg::cmd_t       cmd,
    input  bba_pkg::dp_status_t st
);
    import bba_pkg::*;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_RST_CLEAR;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_RST_CLEAR: if (st.sweep_last) state_next = ST_IDLE;
            ST_IDLE: begin
                if (s_valid) begin
                    unique case (op_t'(s_op))
                        OP_FORMAT: state_next = ST_FMT_CLEAR;
                        OP_ALLOC:  state_next = ST_A_SIZE;
                        OP_FREE:   state_next = ST_F_RD;
                        OP_NOP:    state_next = ST_DONE;
                    endcase
                end
            end
            ST_FMT_CLEAR: if (st.sweep_last) state_next = ST_FMT_CHK;
            ST_FMT_CHK:   state_next = st.fmt_fit ? ST_PUSH2 : ST_FMT_NEXT;
            ST_FMT_NEXT:  state_next = st.cls_zero ? ST_DONE : ST_FMT_CHK;
            ST_A_SIZE:    state_next = st.too_large ? ST_DONE : ST_A_FIND;
            ST_A_FIND:    state_next = st.bin_found ? ST_W_INIT : ST_DONE;
            ST_W_INIT:    state_next = ST_W_STEP;
            ST_W_STEP:    if (!st.walk_more) state_next = ST_D_RD;
            ST_D_RD:      state_next = ST_D_WR;
            ST_D_WR:      state_next = (st.op == OP_ALLOC) ? ST_SPLIT : ST_M_W1;
            ST_SPLIT: begin
                if (!st.split_more) state_next = ST_A_FIN;
                else if (st.half_ok) state_next = ST_PUSH2;
            end
            ST_PUSH2: begin
                priority if (st.op == OP_FORMAT) state_next = ST_FMT_NEXT;
                else if (st.op == OP_ALLOC) state_next = ST_SPLIT;
                else state_next = ST_DONE;
            end
            ST_A_FIN:  state_next = ST_DONE;
            ST_F_RD:   state_next = st.blk_out ? ST_DONE : ST_F_CHK;
            ST_F_CHK:  state_next = st.f_reject ? ST_DONE : ST_F_MARK;
            ST_F_MARK: state_next = ST_F_SET;
            ST_F_SET:  state_next = ST_M_CHK;
            ST_M_CHK:  state_next = st.merge_go ? ST_M_CMP : ST_F_PUSH;
            ST_M_CMP:  state_next = st.bud_match ? ST_D_RD : ST_F_PUSH;
            ST_M_W1:   state_next = ST_M_W2;
            ST_M_W2:   state_next = ST_M_CHK;
            ST_F_PUSH: state_next = ST_PUSH2;
            ST_DONE:   if (!m_valid_reg || m_ready) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd = CMD_NONE;
        unique case (state_reg)
            ST_RST_CLEAR, ST_FMT_CLEAR: cmd = CMD_CLEAR;
            ST_IDLE:     cmd = s_valid ? CMD_START : CMD_NONE;
            ST_FMT_CHK:  cmd = CMD_FMT_CHK;
            ST_FMT_NEXT: cmd = CMD_FMT_NEXT;
            ST_A_SIZE:   cmd = CMD_A_SIZE;
            ST_A_FIND:   cmd = CMD_A_FIND;
            ST_W_INIT:   cmd = CMD_W_INIT;
            ST_W_STEP:   cmd = CMD_W_STEP;
            ST_D_RD:     cmd = CMD_D_RD;
            ST_D_WR:     cmd = CMD_D_WR;
            ST_SPLIT:    cmd = CMD_SPLIT;
            ST_PUSH2:    cmd = CMD_PUSH2;
            ST_A_FIN:    cmd = CMD_A_FIN;
            ST_F_RD:     cmd = CMD_F_RD;
            ST_F_CHK:    cmd = CMD_F_CHK;
            ST_F_MARK:   cmd = CMD_F_MARK;
            ST_F_SET:    cmd = CMD_F_SET;
            ST_M_CHK:    cmd = CMD_M_CHK;
            ST_M_CMP:    cmd = CMD_NONE;
            ST_M_W1:     cmd = CMD_M_W1;
            ST_M_W2:     cmd = CMD_M_W2;
            ST_F_PUSH:   cmd = CMD_F_PUSH;
            ST_DONE:     cmd = (!m_valid_reg || m_ready) ? CMD_OUT : CMD_NONE;
            default:     cmd = CMD_NONE;
        endcase
    end

    always_comb begin
        s_ready = (state_reg == ST_IDLE);
        m_valid = m_valid_reg;
        m_valid_next = m_valid_reg;
        if (cmd == CMD_OUT) m_valid_next = 1'b1;
        else if (m_ready) m_valid_next = 1'b0;
    end

`ifndef NO_ASSERTIONS
    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> state_reg != ST_IDLE)
        else $error("accepted request did not start");
    a_out_sets_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd == CMD_OUT |=> m_valid_reg)
        else $error("result load without valid");
`endif
endmodule

### rtl/bba_datapath.sv
// Allocator datapath: config, control byte and link memories, list heads, work registers.
module bba_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [1:0]                          cfg_index,
    input  logic [bba_pkg::CFG_W-1:0]           cfg_data,
    input  logic [1:0]                          s_op,
    input  logic [bba_pkg::REQ_W-1:0]           s_request_bytes,
    input  logic [bba_pkg::IDX_W-1:0]           s_block_index,
    output logic [1:0]                          m_status,
    output logic [bba_pkg::IDX_W-1:0]           m_granted_index,
    output logic [bba_pkg::CLS_W-1:0]           m_granted_class,
    input  bba_pkg::cmd_t                       cmd,
    output bba_pkg::dp_status_t                 st
);
    import bba_pkg::*;

    function automatic logic [WANT_W-1:0] bit_len(input logic [REQ_W-1:0] v);
        logic [WANT_W-1:0] r;
        r = '0;
        for (int i = 0; i < REQ_W; i++) begin
            if (v[i]) r = WANT_W'(i + 1);
        end
        return r;
    endfunction

    logic [CB_W-1:0]   cb_mem [MAX_BLOCKS];
    logic [LINK_W-1:0] nx_mem [MAX_BLOCKS];
    logic [LINK_W-1:0] pv_mem [MAX_BLOCKS];

    logic [3:0]        atom_log_reg;
    logic [10:0]       block_count_reg;
    logic [REQ_W-1:0]  max_req_reg;
    logic [LINK_W-1:0] heads_reg [TOP_CLASS+1];
    logic [IDX_W-1:0]  sweep_reg;

    op_t               op_reg;
    logic [REQ_W-1:0]  req_reg;
    logic [IDX_W-1:0]  blk_reg, bud_reg, pushat_reg;
    logic [WANT_W-1:0] want_reg;
    logic [CLS_W-1:0]  bin_reg, cls_reg;
    logic [10:0]       pos_reg;
    logic [LINK_W-1:0] cur_reg, best_reg, steps_reg, old_reg;
    logic              first_reg;
    logic [1:0]        res_status_reg, m_status_reg;
    logic [IDX_W-1:0]  res_idx_reg, m_idx_reg;
    logic [CLS_W-1:0]  res_cls_reg, m_cls_reg;
    logic [CB_W-1:0]   rd_cb_reg;
    logic [LINK_W-1:0] rd_nx_reg, rd_pv_reg;

    logic [10:0]       pool_n;
    logic [3:0]        shift;
    logic [WANT_W-1:0] want_c, req_bits;
    logic              found_c;
    logic [CLS_W-1:0]  bin_c, bin_dn, dcls;
    logic [LINK_W-1:0] cur_eff, half;
    logic [11:0]       len_c, rd_len, bud_c;
    logic              too_large, walk_more, split_more, half_ok, fmt_fit;
    logic              blk_out, f_reject, merge_go, bud_match, bud_lower;

    logic              push_en;
    logic [IDX_W-1:0]  push_at;
    logic [CLS_W-1:0]  push_cls;

    logic              cb_we, nx_we, pv_we, cb_re, lk_re;
    logic [IDX_W-1:0]  cb_waddr, nx_waddr, pv_waddr, cb_raddr, lk_raddr;
    logic [CB_W-1:0]   cb_wdata;
    logic [LINK_W-1:0] nx_wdata, pv_wdata;

    always_comb begin
        pool_n   = (block_count_reg > 11'(MAX_BLOCKS)) ? 11'(MAX_BLOCKS) : block_count_reg;
        shift    = (atom_log_reg < 4'd3) ? 4'd3 : atom_log_reg;
        req_bits = bit_len(req_reg - 24'd1);
        want_c   = (req_reg <= (24'd1 << shift)) ? '0 : req_bits - {1'b0, shift};
        too_large = req_reg > max_req_reg;

        found_c = 1'b0;
        bin_c   = '0;
        for (int c = TOP_CLASS; c >= 0; c--) begin
            if (WANT_W'(c) >= want_reg && !heads_reg[c][LINK_W-1]) begin
                found_c = 1'b1;
                bin_c   = CLS_W'(c);
            end
        end

        cur_eff   = first_reg ? cur_reg : rd_nx_reg;
        walk_more = !cur_eff[LINK_W-1] && !steps_reg[LINK_W-1];

        split_more = {1'b0, bin_reg} > want_reg;
        bin_dn     = bin_reg - 4'd1;
        half       = best_reg + (11'd1 << bin_dn);
        half_ok    = !half[LINK_W-1];

        len_c   = 12'd1 << cls_reg;
        fmt_fit = ({1'b0, pos_reg} + len_c) <= {1'b0, pool_n};

        blk_out  = {1'b0, blk_reg} >= pool_n;
        rd_len   = 12'd1 << rd_cb_reg[3:0];
        f_reject = rd_cb_reg[5] || (rd_cb_reg[4:0] > 5'(TOP_CLASS))
                   || (({2'b0, blk_reg} + rd_len) > {1'b0, pool_n});

        bud_c     = ((({2'b0, blk_reg}) >> cls_reg) & 12'd1) != 12'd0
                    ? {2'b0, blk_reg} - len_c : {2'b0, blk_reg} + len_c;
        merge_go  = (cls_reg < CLS_W'(TOP_CLASS)) && ((bud_c + len_c) <= {1'b0, pool_n});
        bud_match = rd_cb_reg == (FREE_MARK | {2'b0, cls_reg});
        bud_lower = bud_reg < blk_reg;
        dcls      = (op_reg == OP_ALLOC) ? bin_reg : cls_reg;

        st.op         = op_reg;
        st.sweep_last = &sweep_reg;
        st.too_large  = too_large;
        st.bin_found  = found_c;
        st.walk_more  = walk_more;
        st.split_more = split_more;
        st.half_ok    = half_ok;
        st.fmt_fit    = fmt_fit;
        st.cls_zero   = cls_reg == '0;
        st.blk_out    = blk_out;
        st.f_reject   = f_reject;
        st.merge_go   = merge_go;
        st.bud_match  = bud_match;
    end

    always_comb begin
        push_en  = 1'b0;
        push_at  = '0;
        push_cls = '0;
        cb_we = 1'b0; cb_waddr = '0; cb_wdata = '0;
        nx_we = 1'b0; nx_waddr = '0; nx_wdata = '0;
        pv_we = 1'b0; pv_waddr = '0; pv_wdata = '0;
        cb_re = 1'b0; cb_raddr = '0;
        lk_re = 1'b0; lk_raddr = '0;
        unique case (cmd)
            CMD_CLEAR: begin
                cb_we = 1'b1; cb_waddr = sweep_reg; cb_wdata = '0;
            end
            CMD_FMT_CHK: begin
                if (fmt_fit) begin
                    cb_we = 1'b1; cb_waddr = pos_reg[IDX_W-1:0];
                    cb_wdata = FREE_MARK | {2'b0, cls_reg};
                    push_en = 1'b1; push_at = pos_reg[IDX_W-1:0]; push_cls = cls_reg;
                end
            end
            CMD_SPLIT: begin
                if (split_more && half_ok) begin
                    cb_we = 1'b1; cb_waddr = half[IDX_W-1:0];
                    cb_wdata = FREE_MARK | {2'b0, bin_dn};
                    push_en = 1'b1; push_at = half[IDX_W-1:0]; push_cls = bin_dn;
                end
            end
            CMD_F_PUSH: begin
                push_en = 1'b1; push_at = blk_reg; push_cls = cls_reg;
            end
            CMD_PUSH2: begin
                if (!old_reg[LINK_W-1]) begin
                    pv_we = 1'b1; pv_waddr = old_reg[IDX_W-1:0];
                    pv_wdata = {1'b0, pushat_reg};
                end
            end
            CMD_W_STEP: begin
                lk_re = walk_more; lk_raddr = cur_eff[IDX_W-1:0];
            end
            CMD_D_RD: begin
                lk_re = 1'b1;
                lk_raddr = (op_reg == OP_ALLOC) ? best_reg[IDX_W-1:0] : bud_reg;
            end
            CMD_D_WR: begin
                if (!rd_pv_reg[LINK_W-1]) begin
                    nx_we = 1'b1; nx_waddr = rd_pv_reg[IDX_W-1:0]; nx_wdata = rd_nx_reg;
                end
                if (!rd_nx_reg[LINK_W-1]) begin
                    pv_we = 1'b1; pv_waddr = rd_nx_reg[IDX_W-1:0]; pv_wdata = rd_pv_reg;
                end
            end
            CMD_A_FIN: begin
                cb_we = 1'b1; cb_waddr = best_reg[IDX_W-1:0]; cb_wdata = {1'b0, want_reg};
            end
            CMD_F_RD: begin
                cb_re = 1'b1; cb_raddr = blk_reg;
            end
            CMD_F_CHK: begin
                cb_re = 1'b1;
                cb_raddr = IDX_W'({2'b0, blk_reg} + rd_len - 12'd1);
            end
            CMD_F_MARK: begin
                cb_we = 1'b1;
                cb_waddr = IDX_W'({2'b0, blk_reg} + len_c - 12'd1);
                cb_wdata = rd_cb_reg | FREE_MARK;
            end
            CMD_F_SET: begin
                cb_we = 1'b1; cb_waddr = blk_reg; cb_wdata = FREE_MARK | {2'b0, cls_reg};
            end
            CMD_M_CHK: begin
                cb_re = merge_go; cb_raddr = bud_c[IDX_W-1:0];
            end
            CMD_M_W1: begin
                cb_we = 1'b1; cb_waddr = bud_lower ? bud_reg : blk_reg;
                cb_wdata = FREE_MARK | {2'b0, cls_reg};
            end
            CMD_M_W2: begin
                cb_we = 1'b1; cb_waddr = bud_lower ? blk_reg : bud_reg; cb_wdata = '0;
            end
            default: ;
        endcase
        if (push_en) begin
            nx_we = 1'b1; nx_waddr = push_at; nx_wdata = heads_reg[push_cls];
            pv_we = 1'b1; pv_waddr = push_at; pv_wdata = NO_LINK;
        end
    end

    always_ff @(posedge aclk) begin
        if (cb_we) cb_mem[cb_waddr] <= cb_wdata;
        if (nx_we) nx_mem[nx_waddr] <= nx_wdata;
        if (pv_we) pv_mem[pv_waddr] <= pv_wdata;
        if (cb_re) rd_cb_reg <= cb_mem[cb_raddr];
        if (lk_re) begin
            rd_nx_reg <= nx_mem[lk_raddr];
            rd_pv_reg <= pv_mem[lk_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            atom_log_reg    <= 4'd3;
            block_count_reg <= 11'd1024;
            max_req_reg     <= 24'hffffff;
            sweep_reg       <= '0;
            for (int c = 0; c <= TOP_CLASS; c++) heads_reg[c] <= NO_LINK;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_idx_t'(cfg_index))
                    CFG_ATOM_LOG:    atom_log_reg    <= cfg_data[3:0];
                    CFG_BLOCK_COUNT: block_count_reg <= cfg_data[10:0];
                    CFG_MAX_REQUEST: max_req_reg     <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd == CMD_CLEAR) sweep_reg <= sweep_reg + 10'd1;
            if (cmd == CMD_START && op_t'(s_op) == OP_FORMAT) begin
                sweep_reg <= '0;
                for (int c = 0; c <= TOP_CLASS; c++) heads_reg[c] <= NO_LINK;
            end
            if (push_en) heads_reg[push_cls] <= {1'b0, push_at};
            if (cmd == CMD_D_WR && rd_pv_reg[LINK_W-1]) heads_reg[dcls] <= rd_nx_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_en) begin
            old_reg    <= heads_reg[push_cls];
            pushat_reg <= push_at;
        end
        unique case (cmd)
            CMD_START: begin
                op_reg         <= op_t'(s_op);
                req_reg        <= s_request_bytes;
                blk_reg        <= s_block_index;
                res_status_reg <= RES_OK;
                res_idx_reg    <= '0;
                res_cls_reg    <= '0;
                pos_reg        <= '0;
                cls_reg        <= CLS_W'(TOP_CLASS);
            end
            CMD_A_SIZE: begin
                want_reg <= want_c;
                if (too_large) res_status_reg <= RES_TOO_LARGE;
            end
            CMD_A_FIND: begin
                bin_reg <= bin_c;
                if (!found_c) res_status_reg <= RES_NO_MEM;
            end
            CMD_W_INIT: begin
                cur_reg   <= heads_reg[bin_reg];
                best_reg  <= heads_reg[bin_reg];
                steps_reg <= '0;
                first_reg <= 1'b1;
            end
            CMD_W_STEP: begin
                if (walk_more) begin
                    if (cur_eff < best_reg) best_reg <= cur_eff;
                    steps_reg <= steps_reg + 11'd1;
                    first_reg <= 1'b0;
                end
            end
            CMD_SPLIT:    if (split_more) bin_reg <= bin_dn;
            CMD_A_FIN: begin
                res_idx_reg <= best_reg[IDX_W-1:0];
                res_cls_reg <= want_reg[CLS_W-1:0];
            end
            CMD_FMT_CHK:  if (fmt_fit) pos_reg <= pos_reg + len_c[10:0];
            CMD_FMT_NEXT: if (cls_reg != '0) cls_reg <= cls_reg - 4'd1;
            CMD_F_CHK:    cls_reg <= rd_cb_reg[3:0];
            CMD_M_CHK:    bud_reg <= bud_c[IDX_W-1:0];
            CMD_D_WR:     if (op_reg != OP_ALLOC) cls_reg <= cls_reg + 4'd1;
            CMD_M_W2:     if (bud_lower) blk_reg <= bud_reg;
            CMD_OUT: begin
                m_status_reg <= res_status_reg;
                m_idx_reg    <= res_idx_reg;
                m_cls_reg    <= res_cls_reg;
            end
            default: ;
        endcase
    end

    assign cfg_ready       = 1'b1;
    assign m_status        = m_status_reg;
    assign m_granted_index = m_idx_reg;
    assign m_granted_class = m_cls_reg;

`ifndef NO_ASSERTIONS
    a_grant_class: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd == CMD_A_FIN |-> want_reg <= WANT_W'(TOP_CLASS))
        else $error("granted class above top class");
    a_split_order: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd == CMD_SPLIT |-> {1'b0, bin_reg} >= want_reg)
        else $error("split below wanted class");
`endif
endmodule

### rtl/buddy_block_allocator.sv
// Top level: binary buddy allocator over up to 1024 atoms.
// Throughput: one request at a time; s_ready is high only while the sequencer is idle.
// Reset: synchronous active-low; afterwards a pass clears all the control bytes
// with s_ready low, then list heads are empty and registers hold 3, 1024, 16777215.
module buddy_block_allocator (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [1:0]                    cfg_index,
    input  logic [bba_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_op,
    input  logic [bba_pkg::REQ_W-1:0]     s_request_bytes,
    input  logic [bba_pkg::IDX_W-1:0]     s_block_index,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [1:0]                    m_status,
    output logic [bba_pkg::IDX_W-1:0]     m_granted_index,
    output logic [bba_pkg::CLS_W-1:0]     m_granted_class
);
    import bba_pkg::*;

    cmd_t       cmd;
    dp_status_t st;

    bba_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_op    (s_op),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .st      (st)
    );

    bba_datapath u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_op            (s_op),
        .s_request_bytes (s_request_bytes),
        .s_block_index   (s_block_index),
        .m_status        (m_status),
        .m_granted_index (m_granted_index),
        .m_granted_class (m_granted_class),
        .cmd             (cmd),
        .st              (st)
    );
endmodule
